>>> rtl/assert_macros.svh
// Assertion helpers shared by spq_datapath and spq_ctrl.
// All three expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define SPQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication
`define SPQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

	// Field widths
	localparam int OP_W           = 2;
	localparam int ID_WIDTH       = 16;
	localparam int PRIORITY_WIDTH = 16;
	localparam int STATUS_W       = 2;
	localparam int HELD_W         = 5;

	// At most this many results for one list request
	localparam int MAX_RESULTS = 16;

	// Request operations
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic [ID_WIDTH-1:0]       entry_id;
		logic [PRIORITY_WIDTH-1:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [ID_WIDTH-1:0]       entry_id_res;
		logic [PRIORITY_WIDTH-1:0] priority_res;
		logic [STATUS_W-1:0]       status;
		logic [HELD_W-1:0]         held;
		logic                      last;
	} res_t;

	// Controller to datapath
	typedef struct packed {
		logic                take;       // latch request, clear list index
		logic                ins;        // sorted insert of the latched entry
		logic                rem;        // shift all slots towards the front
		logic                rot;        // rotate held slots by one, advance list index
		logic                ld_res;     // load the result register
		logic                res_data;   // result carries slot 0 contents
		logic [STATUS_W-1:0] res_status;
		logic                res_last;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            empty;
		logic            full;
		logic            list_emit;  // current list position still produces a result
		logic            list_last;  // current list position is the final result
		logic            list_end;   // current list position is the final held entry
	} stat_t;

endpackage

`default_nettype wire

>>> rtl/spq_datapath.sv
`default_nettype none

module spq_datapath #(
	parameter int CAPACITY = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire spq_pkg::req_t  req,
	input  wire spq_pkg::cmd_t  cmd,
	output spq_pkg::stat_t      stat,
	output spq_pkg::res_t       res
);

	`include "assert_macros.svh"

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	spq_pkg::req_t                        req_q;
	spq_pkg::res_t                        res_q;
	logic [spq_pkg::ID_WIDTH-1:0]         slot_id_q  [CAPACITY];
	logic [spq_pkg::PRIORITY_WIDTH-1:0]   slot_pri_q [CAPACITY];
	logic [CAPACITY-1:0]                  ge;
	logic [CW-1:0]                        count_q;
	logic [CW-1:0]                        count_nx;
	logic [IW-1:0]                        idx_q;
	logic [CW-1:0]                        idx_p1;

	// Request register
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q <= req;
		end
	end

	// Held count
	always_comb begin
		count_nx = count_q;
		if (cmd.ins) begin
			count_nx = count_q + CW'(1);
		end else if (cmd.rem) begin
			count_nx = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nx;
		end
	end

	// List position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.take) begin
			idx_q <= '0;
		end else if (cmd.rot) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	assign idx_p1 = CW'(idx_q) + CW'(1);

	// Slot cells: each compares itself against the new priority and
	// takes its new value from itself, a neighbour or the request
	for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
		assign ge[i] = (CW'(i) < count_q) && (slot_pri_q[i] >= req_q.priority_req);

		always_ff @(posedge clk) begin
			if (cmd.ins) begin
				if (!ge[i]) begin
					if (i == 0) begin
						slot_id_q[i]  <= req_q.entry_id;
						slot_pri_q[i] <= req_q.priority_req;
					end else if (ge[(i == 0) ? 0 : i-1]) begin
						slot_id_q[i]  <= req_q.entry_id;
						slot_pri_q[i] <= req_q.priority_req;
					end else begin
						slot_id_q[i]  <= slot_id_q[(i == 0) ? 0 : i-1];
						slot_pri_q[i] <= slot_pri_q[(i == 0) ? 0 : i-1];
					end
				end
			end else if (cmd.rem) begin
				if (i < CAPACITY - 1) begin
					slot_id_q[i]  <= slot_id_q[(i < CAPACITY - 1) ? i+1 : i];
					slot_pri_q[i] <= slot_pri_q[(i < CAPACITY - 1) ? i+1 : i];
				end
			end else if (cmd.rot) begin
				// last held slot wraps round to the front entry
				if ((i == CAPACITY - 1) || (CW'(i) + CW'(1) == count_q)) begin
					slot_id_q[i]  <= slot_id_q[0];
					slot_pri_q[i] <= slot_pri_q[0];
				end else begin
					slot_id_q[i]  <= slot_id_q[(i < CAPACITY - 1) ? i+1 : i];
					slot_pri_q[i] <= slot_pri_q[(i < CAPACITY - 1) ? i+1 : i];
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.ld_res) begin
			res_q.entry_id_res <= cmd.res_data ? slot_id_q[0]  : '0;
			res_q.priority_res <= cmd.res_data ? slot_pri_q[0] : '0;
			res_q.status       <= cmd.res_status;
			res_q.held         <= spq_pkg::HELD_W'(count_nx);
			res_q.last         <= cmd.res_last;
		end
	end

	assign res = res_q;

	// Status to controller
	always_comb begin
		stat.op        = req_q.op;
		stat.empty     = (count_q == '0);
		stat.full      = (count_q == CW'(CAPACITY));
		stat.list_emit = (32'(idx_q) < spq_pkg::MAX_RESULTS);
		stat.list_end  = (idx_p1 == count_q);
		stat.list_last = (idx_p1 == count_q) || (32'(idx_p1) == spq_pkg::MAX_RESULTS);
	end

	`SPQ_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "held count beyond capacity")
	`SPQ_ASSERT_IMPL(a_ins_room, cmd.ins, count_q != CW'(CAPACITY), "insert into full queue")
	`SPQ_ASSERT_NEXT(a_rem_count, cmd.rem, count_q == $past(count_q) - CW'(1),
		"remove did not drop held count")

endmodule

`default_nettype wire

>>> rtl/spq_ctrl.sv
`default_nettype none

module spq_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     req_valid,
	input  wire logic [spq_pkg::OP_W-1:0] req_op,
	output logic                          req_ready,
	output logic                          res_valid,
	input  wire logic                     res_ready,
	input  wire spq_pkg::stat_t           stat,
	output spq_pkg::cmd_t                 cmd
);

	`include "assert_macros.svh"

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_LIST = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       res_valid_q;
	logic       out_free;

	assign out_free  = !res_valid_q || res_ready;
	assign req_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;

	// Sequencer
	always_comb begin
		cmd            = '0;
		cmd.res_status = spq_pkg::ST_DONE;
		state_nx       = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.take = req_valid;
				if (req_valid && (req_op == spq_pkg::OP_INSERT ||
						req_op == spq_pkg::OP_REMOVE || req_op == spq_pkg::OP_LIST)) begin
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					state_nx     = S_IDLE;
					cmd.ld_res   = 1'b1;
					cmd.res_last = 1'b1;
					unique case (stat.op)
						spq_pkg::OP_INSERT: begin
							if (stat.full) begin
								cmd.res_status = spq_pkg::ST_FULL;
							end else begin
								cmd.ins = 1'b1;
							end
						end
						spq_pkg::OP_REMOVE: begin
							if (stat.empty) begin
								cmd.res_status = spq_pkg::ST_EMPTY;
							end else begin
								cmd.rem      = 1'b1;
								cmd.res_data = 1'b1;
							end
						end
						spq_pkg::OP_LIST: begin
							if (stat.empty) begin
								cmd.res_status = spq_pkg::ST_EMPTY;
							end else begin
								cmd.ld_res   = 1'b0;
								cmd.res_last = 1'b0;
								state_nx     = S_LIST;
							end
						end
						default: begin
							cmd.ld_res   = 1'b0;
							cmd.res_last = 1'b0;
						end
					endcase
				end
			end
			S_LIST: begin
				// entries past the result limit still rotate to restore order
				if (!stat.list_emit || out_free) begin
					cmd.rot = 1'b1;
					if (stat.list_emit) begin
						cmd.ld_res   = 1'b1;
						cmd.res_data = 1'b1;
						cmd.res_last = stat.list_last;
					end
					if (stat.list_end) begin
						state_nx = S_IDLE;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.ld_res) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	`SPQ_ASSERT_IMPL(a_no_overwrite, cmd.ld_res, !res_valid_q || res_ready,
		"result overwritten before taken")
	`SPQ_ASSERT(a_one_update, $onehot0({cmd.ins, cmd.rem, cmd.rot}), "conflicting slot updates")
	`SPQ_ASSERT_IMPL(a_list_held, state_q == S_LIST, !stat.empty, "listing an empty queue")

endmodule

`default_nettype wire

>>> rtl/stable_priority_queue.sv
// Insert and remove: the request is latched in S_IDLE and the result registered from S_EXEC
// once the result port is free; no new request is taken until the block is back in S_IDLE.
// List: one slot rotation per cycle for N held entries (one result each for the first 16),
// slowed only by a stalled result port.
// Reset (arst_n low) empties the queue and the result port; slot contents are not cleared.
`default_nettype none

module stable_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire spq_pkg::req_t req,
	output logic               res_valid,
	input  wire logic          res_ready,
	output spq_pkg::res_t      res
);

	spq_pkg::cmd_t  cmd;
	spq_pkg::stat_t stat;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.op),
		.req_ready (req_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	spq_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.res    (res)
	);

endmodule

`default_nettype wire

>>> dv/stable_priority_queue_tb.sv
`default_nettype none

module stable_priority_queue_tb;

	localparam int QUEUE_DEPTH = 16;
	// Op code the block must ignore without a result
	localparam logic [spq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	// Cycles allowed after the last result for stray output
	localparam int SETTLE_CYCLES = 20;

	// Phases of the random part, steering the fill level
	localparam int PH_FILL    = 0;
	localparam int PH_DRAIN   = 1;
	localparam int PH_BALANCE = 2;

	// Tracks queue contents and the results each request should cause
	class queue_tracker;
		logic [spq_pkg::ID_WIDTH-1:0]       slot_id[$];
		logic [spq_pkg::PRIORITY_WIDTH-1:0] slot_pri[$];
		spq_pkg::res_t                      pending_results[$];
		int                                 errors;

		function new();
			errors = 0;
		endfunction

		// Apply an accepted request and queue its expected results
		function void note_request(spq_pkg::req_t r);
			spq_pkg::res_t x;
			int            pos;
			int            n;
			x = '0;
			x.last = 1'b1;
			case (r.op)
			spq_pkg::OP_INSERT: begin
				if (slot_id.size() >= QUEUE_DEPTH) begin
					x.status = spq_pkg::ST_FULL;
				end else begin
					// behind every held entry of equal or higher priority
					pos = 0;
					while (pos < slot_pri.size() && slot_pri[pos] >= r.priority_req)
						pos++;
					slot_id.insert(pos, r.entry_id);
					slot_pri.insert(pos, r.priority_req);
					x.status = spq_pkg::ST_DONE;
				end
				x.held = spq_pkg::HELD_W'(slot_id.size());
				pending_results.push_back(x);
			end
			spq_pkg::OP_REMOVE: begin
				if (slot_id.size() == 0) begin
					x.status = spq_pkg::ST_EMPTY;
				end else begin
					x.entry_id_res = slot_id.pop_front();
					x.priority_res = slot_pri.pop_front();
					x.status = spq_pkg::ST_DONE;
				end
				x.held = spq_pkg::HELD_W'(slot_id.size());
				pending_results.push_back(x);
			end
			spq_pkg::OP_LIST: begin
				if (slot_id.size() == 0) begin
					x.status = spq_pkg::ST_EMPTY;
					pending_results.push_back(x);
				end else begin
					n = (slot_id.size() < spq_pkg::MAX_RESULTS) ? slot_id.size() :
						spq_pkg::MAX_RESULTS;
					for (int k = 0; k < n; k++) begin
						x.entry_id_res = slot_id[k];
						x.priority_res = slot_pri[k];
						x.status = spq_pkg::ST_DONE;
						x.held = spq_pkg::HELD_W'(slot_id.size());
						x.last = (k == n - 1);
						pending_results.push_back(x);
					end
				end
			end
			default: ;
			endcase
		endfunction

		function void compare_field(string name, int unsigned exp, int unsigned act);
			if (exp != act) begin
				$error("%s mismatch: expected %0h, got %0h", name, exp, act);
				errors++;
			end
		endfunction

		// Compare one result against the oldest expectation
		function void check_result(spq_pkg::res_t got);
			spq_pkg::res_t exp;
			if (pending_results.size() == 0) begin
				$error("unexpected result: id %0h pri %0h status %0d held %0d last %0b",
					got.entry_id_res, got.priority_res, got.status, got.held, got.last);
				errors++;
				return;
			end
			exp = pending_results.pop_front();
			compare_field("entry_id_res", 32'(exp.entry_id_res), 32'(got.entry_id_res));
			compare_field("priority_res", 32'(exp.priority_res), 32'(got.priority_res));
			compare_field("status", 32'(exp.status), 32'(got.status));
			compare_field("held", 32'(exp.held), 32'(got.held));
			compare_field("last", 32'(exp.last), 32'(got.last));
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	spq_pkg::req_t req;
	logic          res_valid;
	logic          res_ready;
	spq_pkg::res_t res;

	queue_tracker tracker;
	bit           steady_run;

	stable_priority_queue #(
		.CAPACITY(QUEUE_DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones, none in steady stretches
	function automatic int idle_cycles();
		int r;
		if (steady_run)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic spq_pkg::req_t make_req(logic [spq_pkg::OP_W-1:0] op,
		logic [spq_pkg::ID_WIDTH-1:0] id, logic [spq_pkg::PRIORITY_WIDTH-1:0] pri);
		spq_pkg::req_t r;
		r.op = op;
		r.entry_id = id;
		r.priority_req = pri;
		return r;
	endfunction

	// Present one request and hold it until taken
	task automatic send_request(input spq_pkg::req_t r);
		int gap;
		gap = idle_cycles();
		@(negedge clk);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req = r;
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
		tracker.note_request(r);
	endtask

	task automatic wait_drained();
		while (tracker.pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Priority mix: narrow range for ties, extremes, or full range
	function automatic logic [spq_pkg::PRIORITY_WIDTH-1:0] pick_priority();
		int m;
		m = $urandom_range(0, 9);
		if (m < 4)
			return spq_pkg::PRIORITY_WIDTH'($urandom_range(0, 3));
		if (m < 6)
			return $urandom_range(0, 1) ? {spq_pkg::PRIORITY_WIDTH{1'b1}} : '0;
		return spq_pkg::PRIORITY_WIDTH'($urandom);
	endfunction

	function automatic logic [spq_pkg::ID_WIDTH-1:0] pick_id();
		return spq_pkg::ID_WIDTH'($urandom);
	endfunction

	function automatic logic [spq_pkg::OP_W-1:0] pick_op(int phase);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return OP_UNUSED;
		case (phase)
		PH_FILL: begin
			if (r < 75) return spq_pkg::OP_INSERT;
			if (r < 88) return spq_pkg::OP_REMOVE;
			return spq_pkg::OP_LIST;
		end
		PH_DRAIN: begin
			if (r < 30) return spq_pkg::OP_INSERT;
			if (r < 85) return spq_pkg::OP_REMOVE;
			return spq_pkg::OP_LIST;
		end
		default: begin
			if (r < 50) return spq_pkg::OP_INSERT;
			if (r < 82) return spq_pkg::OP_REMOVE;
			return spq_pkg::OP_LIST;
		end
		endcase
	endfunction

	// Result side: random back-pressure
	initial begin
		int stall_left;
		stall_left = 0;
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				res_ready = 1'b0;
			end else if (stall_left > 0) begin
				res_ready = 1'b0;
				stall_left--;
			end else if (steady_run) begin
				res_ready = 1'b1;
			end else begin
				int r;
				r = $urandom_range(0, 99);
				if (r < 70) begin
					res_ready = 1'b1;
				end else if (r < 93) begin
					res_ready = 1'b0;
					stall_left = $urandom_range(0, 2);
				end else begin
					res_ready = 1'b0;
					stall_left = $urandom_range(8, 30);
				end
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			tracker.check_result(res);
	end

	// Request stimulus
	initial begin
		int taken;
		int phase;
		logic [spq_pkg::OP_W-1:0] op;
		tracker = new();
		steady_run = 1'b0;
		req_valid = 1'b0;
		req = '0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// empty queue cases and the ignored op
		send_request(make_req(spq_pkg::OP_LIST, 16'h1234, 16'h4321));
		send_request(make_req(spq_pkg::OP_REMOVE, 16'hFFFF, 16'hFFFF));
		send_request(make_req(OP_UNUSED, pick_id(), spq_pkg::PRIORITY_WIDTH'($urandom)));
		// extremes, ties at top, middle and bottom
		send_request(make_req(spq_pkg::OP_INSERT, 16'h0000, 16'h0000));
		send_request(make_req(spq_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF));
		send_request(make_req(spq_pkg::OP_INSERT, 16'h0001, 16'h8000));
		send_request(make_req(spq_pkg::OP_INSERT, 16'h0002, 16'h8000));
		send_request(make_req(spq_pkg::OP_INSERT, 16'h0003, 16'h8000));
		send_request(make_req(spq_pkg::OP_INSERT, 16'hAAAA, 16'h5555));
		send_request(make_req(spq_pkg::OP_INSERT, 16'h5555, 16'hAAAA));
		send_request(make_req(spq_pkg::OP_INSERT, 16'h0004, 16'h0000));
		send_request(make_req(spq_pkg::OP_INSERT, 16'h0005, 16'hFFFF));
		for (int k = 0; k < 7; k++)
			send_request(make_req(spq_pkg::OP_INSERT, pick_id(), pick_priority()));
		// full queue: dropped insert, ignored op, full list, then removes
		send_request(make_req(spq_pkg::OP_INSERT, 16'hDEAD, 16'hFFFF));
		send_request(make_req(OP_UNUSED, 16'hFFFF, 16'hFFFF));
		send_request(make_req(spq_pkg::OP_LIST, 16'h0000, 16'h0000));
		send_request(make_req(spq_pkg::OP_REMOVE, 16'h0000, 16'h0000));
		send_request(make_req(spq_pkg::OP_REMOVE, 16'h0000, 16'h0000));

		// hold off until every result of the directed part is back
		@(negedge clk);
		req_valid = 1'b0;
		wait_drained();

		taken = 0;
		phase = PH_FILL;
		while (taken < 236) begin
			if (taken % 30 == 0) begin
				phase = $urandom_range(PH_FILL, PH_BALANCE);
				steady_run = ($urandom_range(0, 3) == 0);
			end
			if (taken == 120) begin
				@(negedge clk);
				req_valid = 1'b0;
				wait_drained();
			end
			op = pick_op(phase);
			send_request(make_req(op, pick_id(), pick_priority()));
			if (op != OP_UNUSED)
				taken++;
		end

		@(negedge clk);
		req_valid = 1'b0;
		steady_run = 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (tracker.errors == 0 && tracker.pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#20000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> stable_priority_queue.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_datapath.sv
rtl/spq_ctrl.sv
rtl/stable_priority_queue.sv
dv/stable_priority_queue_tb.sv
